// File: rtl/core/i2cmis_pkg.sv
`timescale 1ns / 1ps

package i2cmis_pkg;

    // request codes
    localparam logic [3:0] REQ_START_SEND = 4'd0;
    localparam logic [3:0] REQ_START_RECV = 4'd1;
    localparam logic [3:0] REQ_SB         = 4'd2;
    localparam logic [3:0] REQ_ADDR       = 4'd3;
    localparam logic [3:0] REQ_BTF        = 4'd4;
    localparam logic [3:0] REQ_STOPF      = 4'd5;
    localparam logic [3:0] REQ_TXE        = 4'd6;
    localparam logic [3:0] REQ_RXNE       = 4'd7;
    localparam logic [3:0] REQ_ERROR      = 4'd8;

    // transfer modes
    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_RECV  = 2'd2;

    // notifications
    localparam logic [3:0] NOTE_NONE     = 4'd0;
    localparam logic [3:0] NOTE_TX_DONE  = 4'd1;
    localparam logic [3:0] NOTE_RX_DONE  = 4'd2;
    localparam logic [3:0] NOTE_STOP     = 4'd3;
    localparam logic [3:0] NOTE_DATA_REQ = 4'd4;
    localparam logic [3:0] NOTE_DATA_RCV = 4'd5;
    localparam logic [3:0] NOTE_ERR_BASE = 4'd6;

    localparam logic [2:0] ERR_LAST = 3'd4;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] xfer_len;
        logic [6:0]  slave_addr;
        logic        repeat_start;
        logic        is_master;
        logic        slave_transmitter;
        logic        txe_flag;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
        logic [2:0]  err_kind;
    } item_t;

    typedef struct packed {
        logic [1:0] busy_state;
        logic       start_gen;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       stop_gen;
        logic       ack_level;
        logic [3:0] notify;
    } result_t;

endpackage

// File: rtl/core/i2cmis_seq.sv
`timescale 1ns / 1ps

module i2cmis_seq #(
    parameter int LEN_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  i2cmis_pkg::item_t  item,
    input  logic               ack_control,
    output i2cmis_pkg::result_t res
);

    logic [1:0]          mode_reg, mode_next;
    logic [LEN_BITS-1:0] tx_rem_reg, tx_rem_next;
    logic [LEN_BITS-1:0] rx_rem_reg, rx_rem_next;
    logic [LEN_BITS-1:0] rx_req_reg, rx_req_next;
    logic [6:0]          addr_reg, addr_next;
    logic                keep_reg, keep_next;
    logic                ack_reg, ack_next;
    logic                evt_on_reg, evt_on_next;
    logic                buf_on_reg, buf_on_next;
    logic                err_on_reg, err_on_next;

    always_comb
    begin
        logic [LEN_BITS-1:0] len;
        logic                idle;
        logic                buf_ok;
        logic                busy_mode;

        len       = LEN_BITS'(item.xfer_len);
        busy_mode = (mode_reg == i2cmis_pkg::MODE_SEND) || (mode_reg == i2cmis_pkg::MODE_RECV);
        idle      = !busy_mode;
        buf_ok    = evt_on_reg && buf_on_reg;

        mode_next   = mode_reg;
        tx_rem_next = tx_rem_reg;
        rx_rem_next = rx_rem_reg;
        rx_req_next = rx_req_reg;
        addr_next   = addr_reg;
        keep_next   = keep_reg;
        ack_next    = ack_reg;
        evt_on_next = evt_on_reg;
        buf_on_next = buf_on_reg;
        err_on_next = err_on_reg;

        res            = '0;
        res.busy_state = mode_reg;

        unique case (item.req_type)
            i2cmis_pkg::REQ_START_SEND, i2cmis_pkg::REQ_START_RECV:
            begin
                if (idle)
                begin
                    if (item.req_type == i2cmis_pkg::REQ_START_SEND)
                    begin
                        tx_rem_next = len;
                        mode_next   = i2cmis_pkg::MODE_SEND;
                    end
                    else
                    begin
                        rx_rem_next = len;
                        rx_req_next = len;
                        mode_next   = i2cmis_pkg::MODE_RECV;
                    end
                    addr_next     = item.slave_addr;
                    keep_next     = item.repeat_start;
                    evt_on_next   = 1'b1;
                    buf_on_next   = 1'b1;
                    err_on_next   = 1'b1;
                    res.start_gen = 1'b1;
                end
            end
            i2cmis_pkg::REQ_SB:
            begin
                if (evt_on_reg && busy_mode)
                begin
                    res.dr_write = 1'b1;
                    res.dr_value = {addr_reg, (mode_reg == i2cmis_pkg::MODE_RECV)};
                end
            end
            i2cmis_pkg::REQ_ADDR:
            begin
                if (evt_on_reg && item.is_master && mode_reg == i2cmis_pkg::MODE_RECV
                    && rx_req_reg == LEN_BITS'(1))
                begin
                    ack_next = 1'b0;
                end
            end
            i2cmis_pkg::REQ_BTF:
            begin
                if (evt_on_reg && mode_reg == i2cmis_pkg::MODE_SEND && item.txe_flag
                    && tx_rem_reg == '0)
                begin
                    res.stop_gen = !keep_reg;
                    buf_on_next  = 1'b0;
                    err_on_next  = 1'b0;
                    mode_next    = i2cmis_pkg::MODE_READY;
                    res.notify   = i2cmis_pkg::NOTE_TX_DONE;
                end
            end
            i2cmis_pkg::REQ_STOPF:
            begin
                if (evt_on_reg && !item.is_master)
                begin
                    res.notify = i2cmis_pkg::NOTE_STOP;
                end
            end
            i2cmis_pkg::REQ_TXE:
            begin
                if (buf_ok)
                begin
                    if (item.is_master)
                    begin
                        if (mode_reg == i2cmis_pkg::MODE_SEND && tx_rem_reg != '0)
                        begin
                            res.dr_write = 1'b1;
                            res.dr_value = item.tx_byte;
                            tx_rem_next  = tx_rem_reg - LEN_BITS'(1);
                        end
                    end
                    else if (item.slave_transmitter)
                    begin
                        res.notify = i2cmis_pkg::NOTE_DATA_REQ;
                    end
                end
            end
            i2cmis_pkg::REQ_RXNE:
            begin
                if (buf_ok)
                begin
                    if (item.is_master)
                    begin
                        if (mode_reg == i2cmis_pkg::MODE_RECV)
                        begin
                            if (rx_req_reg != '0 && rx_rem_reg != '0)
                            begin
                                // nack the last byte once the second to last arrives
                                if (rx_req_reg > LEN_BITS'(1) && rx_rem_reg == LEN_BITS'(2))
                                begin
                                    ack_next = 1'b0;
                                end
                                res.rx_valid = 1'b1;
                                res.rx_data  = item.rx_byte;
                                rx_rem_next  = rx_rem_reg - LEN_BITS'(1);
                            end
                            if (rx_rem_next == '0)
                            begin
                                res.stop_gen = !keep_reg;
                                buf_on_next  = 1'b0;
                                err_on_next  = 1'b0;
                                rx_req_next  = '0;
                                mode_next    = i2cmis_pkg::MODE_READY;
                                if (ack_control)
                                begin
                                    ack_next = 1'b1;
                                end
                                res.notify = i2cmis_pkg::NOTE_RX_DONE;
                            end
                        end
                    end
                    else if (!item.slave_transmitter)
                    begin
                        res.notify = i2cmis_pkg::NOTE_DATA_RCV;
                    end
                end
            end
            i2cmis_pkg::REQ_ERROR:
            begin
                if (err_on_reg && item.err_kind <= i2cmis_pkg::ERR_LAST)
                begin
                    res.notify = i2cmis_pkg::NOTE_ERR_BASE + {1'b0, item.err_kind};
                end
            end
            default:
            begin
            end
        endcase

        res.ack_level = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= i2cmis_pkg::MODE_READY;
            tx_rem_reg <= '0;
            rx_rem_reg <= '0;
            rx_req_reg <= '0;
            addr_reg   <= '0;
            keep_reg   <= 1'b0;
            ack_reg    <= 1'b1;
            evt_on_reg <= 1'b0;
            buf_on_reg <= 1'b0;
            err_on_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            tx_rem_reg <= tx_rem_next;
            rx_rem_reg <= rx_rem_next;
            rx_req_reg <= rx_req_next;
            addr_reg   <= addr_next;
            keep_reg   <= keep_next;
            ack_reg    <= ack_next;
            evt_on_reg <= evt_on_next;
            buf_on_reg <= buf_on_next;
            err_on_reg <= err_on_next;
        end
    end

endmodule

// File: rtl/core/i2c_master_interrupt_sequencer_core.sv
`timescale 1ns / 1ps

// i2c master transfer sequencer, one item per start request or bus event
// input channel: in_valid / in_stall with one port per field; an item is
// taken at a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall, exactly one result per item, in order
// config: cfg_we / cfg_wdata write the ack level restored after a receive;
// write only while no item is in flight
// result path: the input register takes an accepted item; the sequencer result
// then loads into the result register once it is free and out_valid rises
// throughput: one item per cycle while out_stall is low, set by the state
// update loop in the sequencer; a new item enters while a finished result
// still waits; when out_stall is high the result register holds, the input
// register fills, and in_stall rises only while both are occupied
// reset: all transfer state cleared, mode ready, ack level 1, interrupts off,
// both registers empty
module i2c_master_interrupt_sequencer_core #(
    parameter int LEN_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] req_type,
    input  logic [15:0] xfer_len,
    input  logic [6:0] slave_addr,
    input  logic       repeat_start,
    input  logic       is_master,
    input  logic       slave_transmitter,
    input  logic       txe_flag,
    input  logic [7:0] tx_byte,
    input  logic [7:0] rx_byte,
    input  logic [2:0] err_kind,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] busy_state,
    output logic       start_gen,
    output logic       dr_write,
    output logic [7:0] dr_value,
    output logic       rx_valid,
    output logic [7:0] rx_data,
    output logic       stop_gen,
    output logic       ack_level,
    output logic [3:0] notify
);

    logic                ack_ctl_reg;
    logic                in_vld_reg, in_vld_next;
    i2cmis_pkg::item_t   item_reg;
    logic                out_vld_reg, out_vld_next;
    i2cmis_pkg::result_t res_reg;
    i2cmis_pkg::result_t res_next;
    logic                in_take;
    logic                advance;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_ctl_reg <= 1'b1;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ack_ctl_reg <= cfg_wdata;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type          <= req_type;
            item_reg.xfer_len          <= xfer_len;
            item_reg.slave_addr        <= slave_addr;
            item_reg.repeat_start      <= repeat_start;
            item_reg.is_master         <= is_master;
            item_reg.slave_transmitter <= slave_transmitter;
            item_reg.txe_flag          <= txe_flag;
            item_reg.tx_byte           <= tx_byte;
            item_reg.rx_byte           <= rx_byte;
            item_reg.err_kind          <= err_kind;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    i2cmis_seq #(
        .LEN_BITS (LEN_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .ack_control (ack_ctl_reg),
        .res         (res_next)
    );

    assign out_valid  = out_vld_reg;
    assign busy_state = res_reg.busy_state;
    assign start_gen  = res_reg.start_gen;
    assign dr_write   = res_reg.dr_write;
    assign dr_value   = res_reg.dr_value;
    assign rx_valid   = res_reg.rx_valid;
    assign rx_data    = res_reg.rx_data;
    assign stop_gen   = res_reg.stop_gen;
    assign ack_level  = res_reg.ack_level;
    assign notify     = res_reg.notify;

endmodule

// File: rtl/core/i2cmis_chk.sv
`timescale 1ns / 1ps

module i2cmis_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] busy_state,
    input logic       start_gen,
    input logic [7:0] dr_value,
    input logic [3:0] notify
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dr_value) && $stable(notify))
        else $error("stalled result changed");

    // back pressure only comes from a full result register
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // an accepted item reaches the result register when the receiver is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("result missing after accepted item");

    // a start request only issues from ready and carries no notification
    a_start_from_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_gen |-> busy_state == i2cmis_pkg::MODE_READY
            && notify == i2cmis_pkg::NOTE_NONE)
        else $error("start issued while busy");

endmodule

bind i2c_master_interrupt_sequencer_core i2cmis_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .busy_state (busy_state),
    .start_gen  (start_gen),
    .dr_value   (dr_value),
    .notify     (notify)
);
